FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// shared constants for the modular exponentiation unit
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned FIELD_W       = 64;
  localparam int unsigned DEF_OPERAND_W = 64;

endpackage

FILE: rtl/core/modexp_in_if.sv
// ----------------------------------------------------------------------------
// modexp_in_if
// operand channel: base, exponent and modulus with valid/ready
// ----------------------------------------------------------------------------
interface modexp_in_if;
  import modexp_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;
  logic [FIELD_W-1:0] modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink   (input valid, input base, input exponent, input modulus, output ready);

endinterface

FILE: rtl/core/modexp_out_if.sv
// ----------------------------------------------------------------------------
// modexp_out_if
// result channel: residue and zero-modulus flag with valid/ready
// ----------------------------------------------------------------------------
interface modexp_out_if;
  import modexp_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] residue;
  logic               zero_modulus;

  modport source (output valid, output residue, output zero_modulus, input ready);
  modport sink   (input valid, input residue, input zero_modulus, output ready);

endinterface

FILE: rtl/core/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one transaction of base, exponent and modulus; only the low
//   OPERAND_WIDTH bits of each are used. out_ch returns one transaction with
//   the residue and a zero_modulus flag (residue 0 when the modulus is zero).
//   in_ch.ready is high only while the sequencer is idle; one transaction is
//   worked on at a time.
// steps: the base is first reduced mod the modulus; then, for each exponent bit
//   up to the highest set one, a multiply when the bit is set and then a square.
//   a zero modulus goes straight to the output register.
//   every product goes through the single shift-add modular step unit, which
//   retires one multiplier bit per cycle.
// reset: synchronous active-low rst_n returns the sequencer to idle and
//   drops out_ch.valid. a stalled receiver leaves the result in the output
//   register; the unit takes and works one more transaction, then holds it
//   with in_ch.ready low until the output register is free.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
  parameter int unsigned OPERAND_WIDTH = modexp_pkg::DEF_OPERAND_W
) (
  input  logic          clk,
  input  logic          rst_n,
  modexp_in_if.sink     in_ch,
  modexp_out_if.source  out_ch
);
  import modexp_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam int unsigned SW = W + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  e_r, e_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  p_r, p_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          sqr_r, sqr_nxt;
  logic          zm_r, zm_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          res_zm_r, res_zm_nxt;

  // shared modular step unit: (2*p + addend) mod m, addend < m
  logic [W-1:0]  addend;
  logic [W-1:0]  mul_x;
  logic [SW-1:0] s_sum, s_m1, s_m2, d1, d2;
  logic [W-1:0]  step_res;

  assign mul_x  = sqr_r ? b_r : acc_r;
  assign addend = (state_r == ST_RED) ? W'(b_r[cnt_r]) :
                  (b_r[cnt_r] ? mul_x : '0);

  assign s_sum = SW'({p_r, 1'b0}) + SW'(addend);
  assign s_m1  = SW'(m_r);
  assign s_m2  = SW'({m_r, 1'b0});
  assign d1    = s_sum - s_m1;
  assign d2    = s_sum - s_m2;

  always_comb begin
    if (s_sum >= s_m2) begin
      step_res = d2[W-1:0];
    end else if (s_sum >= s_m1) begin
      step_res = d1[W-1:0];
    end else begin
      step_res = s_sum[W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    sqr_nxt       = sqr_r;
    zm_nxt        = zm_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    res_zm_nxt    = res_zm_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          b_nxt   = W'(in_ch.base);
          e_nxt   = W'(in_ch.exponent);
          m_nxt   = W'(in_ch.modulus);
          p_nxt   = '0;
          cnt_nxt = CW'(W - 1);
          if (W'(in_ch.modulus) == '0) begin
            acc_nxt   = '0;
            zm_nxt    = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            zm_nxt    = 1'b0;
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        p_nxt   = step_res;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          b_nxt     = step_res;
          acc_nxt   = W'(m_r != W'(1));
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        p_nxt   = '0;
        cnt_nxt = CW'(W - 1);
        sqr_nxt = ~e_r[0];
        if (e_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        p_nxt   = step_res;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          p_nxt   = '0;
          cnt_nxt = CW'(W - 1);
          if (!sqr_r) begin
            acc_nxt = step_res;
            sqr_nxt = 1'b1;
          end else begin
            b_nxt     = step_res;
            e_nxt     = e_r >> 1;
            state_nxt = ST_CHK;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          res_nxt       = acc_r;
          res_zm_nxt    = zm_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r      <= b_nxt;
    e_r      <= e_nxt;
    m_r      <= m_nxt;
    acc_r    <= acc_nxt;
    p_r      <= p_nxt;
    cnt_r    <= cnt_nxt;
    sqr_r    <= sqr_nxt;
    zm_r     <= zm_nxt;
    res_r    <= res_nxt;
    res_zm_r <= res_zm_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.residue      = FIELD_W'(res_r);
  assign out_ch.zero_modulus = res_zm_r;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
               out_ch.valid && $stable(out_ch.residue))
  `ASSERT_IMPLIES(a_zero_mod_res, clk, rst_n, out_ch.valid && out_ch.zero_modulus,
                  out_ch.residue == '0)
  `ASSERT_IMPLIES(a_partial_below_mod, clk, rst_n,
                  (state_r == ST_RED) || (state_r == ST_MUL), p_r < m_r)
  `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule
